### sv/ptl_pkg.sv
package ptl_pkg;

  localparam int COORD_BITS = 16;

  localparam int CODE_BITS  = 7;
  localparam int WIDTH_BITS = 4;
  localparam int LIMIT_BITS = 12;
  localparam int ATLAS_BITS = 11;
  localparam int AXY_BITS   = 10;

  localparam int QDEPTH    = 2;
  localparam int QPTR_BITS = $clog2(QDEPTH);

  // Character codes with a meaning of their own.
  localparam logic [CODE_BITS-1:0] CH_NUL       = 7'd0;
  localparam logic [CODE_BITS-1:0] CH_NEWLINE   = 7'd10;
  localparam logic [CODE_BITS-1:0] CH_SPACE     = 7'd32;
  localparam logic [CODE_BITS-1:0] CH_BACKSLASH = 7'd92;
  localparam logic [CODE_BITS-1:0] CH_LOWER_N   = 7'd110;

  localparam int SPACE_ADVANCE = 4;
  localparam int LINE_PITCH    = 8;
  localparam int BOTTOM_ROWS   = 24;
  localparam int WRAP_MARGIN   = 14;
  localparam int SPACE_MARGIN  = 24;
  localparam logic [WIDTH_BITS-1:0] MARKER_WIDTH = 4'd8;

  // Configuration register indexes.
  localparam logic REG_LINE_LIMIT  = 1'b0;
  localparam logic REG_ATLAS_WIDTH = 1'b1;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    logic signed [15:0]    screen_x;
    logic signed [15:0]    screen_y;
    logic [CODE_BITS-1:0]  code;
    logic [WIDTH_BITS-1:0] glyph_width;
    logic                  end_marker;
  } draw_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  localparam logic [WIDTH_BITS-1:0] GLYPH_ROM [128] = '{
    4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,4'd8, 4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,
    4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,4'd8, 4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,
    4'd8,4'd2,4'd4,4'd7,4'd6,4'd8,4'd6,4'd2, 4'd4,4'd4,4'd6,4'd6,4'd3,4'd5,4'd2,4'd4,
    4'd6,4'd4,4'd6,4'd6,4'd6,4'd6,4'd6,4'd6, 4'd6,4'd6,4'd2,4'd3,4'd4,4'd5,4'd4,4'd6,
    4'd8,4'd6,4'd6,4'd6,4'd6,4'd6,4'd6,4'd6, 4'd6,4'd2,4'd6,4'd6,4'd6,4'd8,4'd6,4'd6,
    4'd6,4'd6,4'd6,4'd6,4'd6,4'd6,4'd6,4'd8, 4'd6,4'd6,4'd6,4'd4,4'd4,4'd4,4'd6,4'd6,
    4'd3,4'd6,4'd6,4'd6,4'd6,4'd6,4'd5,4'd6, 4'd6,4'd2,4'd6,4'd6,4'd3,4'd8,4'd6,4'd6,
    4'd6,4'd6,4'd6,4'd6,4'd5,4'd6,4'd6,4'd8, 4'd6,4'd6,4'd6,4'd5,4'd3,4'd5,4'd7,4'd7
  };

endpackage

### sv/ptl_front.sv
module ptl_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  input  logic                             in_ready_i,
  input  logic                             first_i,
  input  logic signed [15:0]               start_x_i,
  input  logic signed [15:0]               start_y_i,
  input  logic [ptl_pkg::CODE_BITS-1:0]    char_code_i,
  input  logic [ptl_pkg::LIMIT_BITS-1:0]   line_limit_i,
  output logic                             push_o,
  output ptl_pkg::draw_t                   draw_o
);

  localparam int CB       = ptl_pkg::COORD_BITS;
  localparam int CMP_BITS = ((CB > ptl_pkg::LIMIT_BITS) ? CB : ptl_pkg::LIMIT_BITS) + 2;

  ptl_pkg::coord_t pen_x_q, pen_y_q, ls_x_q, ls_y_q;
  ptl_pkg::coord_t pen_x_d, pen_y_d, ls_x_d, ls_y_d;
  logic esc_q, esc_d, stop_q, stop_d;

  ptl_pkg::coord_t base_px, base_py, base_lsx, base_lsy;
  logic base_esc, base_stop;
  logic active, is_space, is_bs, is_nl, is_glyph, bottom, wrap, accept;
  logic [ptl_pkg::WIDTH_BITS-1:0] rom_w;
  logic signed [CB:0] ydiff;
  ptl_pkg::coord_t px1, px2, py_step;
  logic signed [CMP_BITS-1:0] px1_ext, limit;

  assign accept = in_valid_i & in_ready_i;

  always_comb begin
    base_px   = first_i ? CB'(start_x_i) : pen_x_q;
    base_py   = first_i ? CB'(start_y_i) : pen_y_q;
    base_lsx  = first_i ? CB'(start_x_i) : ls_x_q;
    base_lsy  = first_i ? CB'(start_y_i) : ls_y_q;
    base_esc  = first_i ? 1'b0 : esc_q;
    base_stop = first_i ? 1'b0 : stop_q;

    active   = !base_stop && (char_code_i != ptl_pkg::CH_NUL);
    is_space = (char_code_i == ptl_pkg::CH_SPACE);
    is_bs    = (char_code_i == ptl_pkg::CH_BACKSLASH);
    is_nl    = (char_code_i == ptl_pkg::CH_NEWLINE) ||
               ((char_code_i == ptl_pkg::CH_LOWER_N) && base_esc);
    is_glyph = !is_space && !is_bs && !is_nl;
    rom_w    = ptl_pkg::GLYPH_ROM[char_code_i];

    // Rows used so far on this string, taken without wrap.
    ydiff  = {base_py[CB-1], base_py} - {base_lsy[CB-1], base_lsy};
    bottom = is_nl && (ydiff >= (CB+1)'(ptl_pkg::BOTTOM_ROWS));

    if (is_nl) begin
      px1 = base_lsx;
    end else if (is_space) begin
      px1 = base_px + CB'(ptl_pkg::SPACE_ADVANCE);
    end else if (is_glyph) begin
      px1 = base_px + CB'(rom_w);
    end else begin
      px1 = base_px;
    end

    px1_ext = CMP_BITS'(px1);
    limit   = CMP_BITS'({1'b0, line_limit_i}) - CMP_BITS'(ptl_pkg::WRAP_MARGIN)
            - (is_space ? CMP_BITS'(ptl_pkg::SPACE_MARGIN) : CMP_BITS'(0));
    wrap    = (px1_ext >= limit);
    px2     = wrap ? base_lsx : px1;

    // A newline followed by a wrap moves down two lines.
    case ({is_nl, wrap})
      2'b11:   py_step = base_py + CB'(2 * ptl_pkg::LINE_PITCH);
      2'b10,
      2'b01:   py_step = base_py + CB'(ptl_pkg::LINE_PITCH);
      default: py_step = base_py;
    endcase

    pen_x_d = pen_x_q;
    pen_y_d = pen_y_q;
    ls_x_d  = ls_x_q;
    ls_y_d  = ls_y_q;
    esc_d   = esc_q;
    stop_d  = stop_q;
    if (accept) begin
      ls_x_d = base_lsx;
      ls_y_d = base_lsy;
      if (active) begin
        pen_x_d = px2;
        pen_y_d = py_step;
        esc_d   = is_bs;
        stop_d  = bottom;
      end else begin
        pen_x_d = base_px;
        pen_y_d = base_py;
        esc_d   = base_esc;
        stop_d  = base_stop;
      end
    end

    push_o               = accept && active && (is_glyph || bottom);
    draw_o.screen_x      = 16'(base_px);
    draw_o.screen_y      = 16'(base_py);
    draw_o.code          = bottom ? ptl_pkg::CH_NUL : char_code_i;
    draw_o.glyph_width   = bottom ? ptl_pkg::MARKER_WIDTH : rom_w;
    draw_o.end_marker    = bottom;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pen_x_q <= '0;
      pen_y_q <= '0;
      ls_x_q  <= '0;
      ls_y_q  <= '0;
      esc_q   <= 1'b0;
      stop_q  <= 1'b0;
    end else begin
      pen_x_q <= pen_x_d;
      pen_y_q <= pen_y_d;
      ls_x_q  <= ls_x_d;
      ls_y_q  <= ls_y_d;
      esc_q   <= esc_d;
      stop_q  <= stop_d;
    end
  end

endmodule

### sv/ptl_fifo.sv
module ptl_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  ptl_pkg::draw_t      push_data_i,
  input  logic                pop_i,
  output ptl_pkg::draw_t      pop_data_o,
  output ptl_pkg::fifo_stat_t stat_o
);

  localparam int PW = ptl_pkg::QPTR_BITS;

  ptl_pkg::draw_t mem_q [ptl_pkg::QDEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [PW:0]   count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PW'(ptl_pkg::QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PW'(ptl_pkg::QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign pop_data_o   = mem_q[rd_ptr_q];
  assign stat_o.full  = (count_q == (PW+1)'(ptl_pkg::QDEPTH));
  assign stat_o.empty = (count_q == '0);

endmodule

### sv/ptl_back.sv
module ptl_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  ptl_pkg::fifo_stat_t             fifo_stat_i,
  input  ptl_pkg::draw_t                  fifo_data_i,
  output logic                            pop_o,
  input  logic [ptl_pkg::ATLAS_BITS-1:0]  atlas_width_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic signed [15:0]              screen_x_o,
  output logic signed [15:0]              screen_y_o,
  output logic [ptl_pkg::AXY_BITS-1:0]    atlas_x_o,
  output logic [ptl_pkg::AXY_BITS-1:0]    atlas_y_o,
  output logic [ptl_pkg::WIDTH_BITS-1:0]  glyph_width_o,
  output logic                            end_marker_o
);

  localparam int PB        = ptl_pkg::CODE_BITS + 3;   // code times eight
  localparam int RB        = ptl_pkg::ATLAS_BITS + 1;
  localparam int STEPS     = PB;
  localparam int CNT_BITS  = $clog2(STEPS);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  logic [1:0]          state_q, state_d;
  logic [CNT_BITS-1:0] cnt_q, cnt_d;
  logic [RB-1:0]       rem_q, rem_d, rem_sh;
  logic [PB-1:0]       quo_q, quo_d, dvd_q, dvd_d, prod;
  ptl_pkg::draw_t      entry_q, entry_d;
  logic                load, ge;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    dvd_d   = dvd_q;
    entry_d = entry_q;
    load    = 1'b0;

    // One restoring-division step per cycle: remainder is the atlas column.
    rem_sh = {rem_q[RB-2:0], dvd_q[PB-1]};
    ge     = (rem_sh >= {1'b0, atlas_width_i});

    unique case (state_q)
      ST_IDLE: begin
        load = !fifo_stat_i.empty;
      end
      ST_DIV: begin
        rem_d = ge ? rem_sh - {1'b0, atlas_width_i} : rem_sh;
        quo_d = {quo_q[PB-2:0], ge};
        dvd_d = {dvd_q[PB-2:0], 1'b0};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_ready_i) begin
          state_d = ST_IDLE;
          load    = !fifo_stat_i.empty;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    prod = {fifo_data_i.code, 3'b000};
    if (load) begin
      entry_d = fifo_data_i;
      quo_d   = '0;
      if (atlas_width_i == '0) begin
        rem_d   = RB'(prod);
        state_d = ST_OUT;
      end else begin
        rem_d   = '0;
        dvd_d   = prod;
        cnt_d   = CNT_BITS'(STEPS - 1);
        state_d = ST_DIV;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q   <= rem_d;
    quo_q   <= quo_d;
    dvd_q   <= dvd_d;
    entry_q <= entry_d;
  end

  assign pop_o         = load;
  assign out_valid_o   = (state_q == ST_OUT);
  assign screen_x_o    = entry_q.screen_x;
  assign screen_y_o    = entry_q.screen_y;
  assign atlas_x_o     = rem_q[ptl_pkg::AXY_BITS-1:0];
  assign atlas_y_o     = {quo_q[ptl_pkg::AXY_BITS-4:0], 3'b000};
  assign glyph_width_o = entry_q.glyph_width;
  assign end_marker_o  = entry_q.end_marker;

endmodule

### sv/proportional_text_layout.sv
// Lays out a stream of character codes as 8x8 proportional glyph draws. The front end takes
// one character word per cycle whenever its two-entry draw queue has room, updating the pen,
// line start, escape and stop state in that same cycle. Spaces, backslashes, code zero,
// ordinary newlines and characters of an ended string produce no draw; a newline that comes
// once three lines are filled draws the end marker and ends the string. Each draw then passes
// through the back end: a one-bit-per-cycle divider splits code*8 by the atlas width into
// atlas column and row, and the output register holds the result (atlas width zero skips the
// divider). Runs without glyphs go at one character per cycle while the draw queue has room;
// the back end takes a new draw only as the last one leaves its output register. Write the
// configuration registers only while the block is idle; the config port is always ready.
module proportional_text_layout (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [39:0]                    s_axis_tdata,  // start_x, start_y, char_code, pad
  input  logic                           s_axis_tuser,  // first
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // screen_x, screen_y, atlas_x, atlas_y, glyph_width
  output logic [55:0]                    m_axis_tdata,
  output logic                           m_axis_tuser,  // end_marker
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic                           cfg_index_i,
  input  logic [ptl_pkg::LIMIT_BITS-1:0] cfg_data_i
);

  logic [ptl_pkg::LIMIT_BITS-1:0] line_limit_q;
  logic [ptl_pkg::ATLAS_BITS-1:0] atlas_width_q;

  logic                push, pop;
  ptl_pkg::draw_t      push_data, pop_data;
  ptl_pkg::fifo_stat_t fifo_stat;

  logic signed [15:0]               screen_x, screen_y;
  logic [ptl_pkg::AXY_BITS-1:0]     atlas_x, atlas_y;
  logic [ptl_pkg::WIDTH_BITS-1:0]   glyph_width;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_limit_q  <= 12'd320;
      atlas_width_q <= 11'd128;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        ptl_pkg::REG_LINE_LIMIT:  line_limit_q  <= cfg_data_i;
        ptl_pkg::REG_ATLAS_WIDTH: atlas_width_q <= cfg_data_i[ptl_pkg::ATLAS_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready = !fifo_stat.full;

  ptl_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_i   (s_axis_tready),
    .first_i      (s_axis_tuser),
    .start_x_i    (s_axis_tdata[15:0]),
    .start_y_i    (s_axis_tdata[31:16]),
    .char_code_i  (s_axis_tdata[38:32]),
    .line_limit_i (line_limit_q),
    .push_o       (push),
    .draw_o       (push_data)
  );

  ptl_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .stat_o      (fifo_stat)
  );

  ptl_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fifo_stat_i   (fifo_stat),
    .fifo_data_i   (pop_data),
    .pop_o         (pop),
    .atlas_width_i (atlas_width_q),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .screen_x_o    (screen_x),
    .screen_y_o    (screen_y),
    .atlas_x_o     (atlas_x),
    .atlas_y_o     (atlas_y),
    .glyph_width_o (glyph_width),
    .end_marker_o  (m_axis_tuser)
  );

  assign m_axis_tdata = {glyph_width, atlas_y, atlas_x, screen_y, screen_x};

  assert property (@(posedge clk_i) disable iff (!rst_ni) push |-> !fifo_stat.full)
    else $error("draw queue written while full");

  assert property (@(posedge clk_i) disable iff (!rst_ni) pop |-> !fifo_stat.empty)
    else $error("draw queue read while empty");

  // The end marker is glyph zero: atlas origin, full width.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (m_axis_tvalid && m_axis_tuser) |->
      (glyph_width == ptl_pkg::MARKER_WIDTH && atlas_x == '0 && atlas_y == '0))
    else $error("end marker word carries wrong glyph data");

endmodule
